// ===== rtl/vfd_scan_frame_controller_defines.svh =====
// assertion macros for the scan frame controller checker
`ifndef VFD_SCAN_FRAME_CONTROLLER_DEFINES_SVH
`define VFD_SCAN_FRAME_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define VFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vfd_pkg.sv =====
package vfd_pkg;

   localparam int NUM_GATES   = 10;
   localparam int NUM_LEDS    = 6;
   localparam int ROW_W       = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
   localparam int SEG_W       = 16;
   localparam int WORD_W      = 32;
   localparam int GATE_W      = 4;
   localparam int GLYPH_COUNT = 24;

   typedef enum logic [2:0] {
      REQ_SCAN  = 3'd0,
      REQ_BIT   = 3'd1,
      REQ_DIGIT = 3'd2,
      REQ_LED   = 3'd3,
      REQ_FILL  = 3'd4
   } vfd_req_code_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [3:0] gate_row;
      logic [3:0] seg_column;
      logic [2:0] digit_pos;
      logic [4:0] digit_code;
      logic [2:0] led_index;
      logic       bit_value;
   } vfd_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] shift_word;
      logic [GATE_W-1:0] scan_gate;
   } vfd_rsp_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
      logic [SEG_W-1:0] data;
   } vfd_wr_type;

   typedef struct packed {
      logic [SEG_W-1:0]  new_row;
      logic [WORD_W-1:0] word;
   } vfd_alu_type;

   function automatic logic [7:0] vfd_glyph(input logic [4:0] code);
      logic [7:0] g;
      case (code)
         5'd0:    g = 8'h88;
         5'd1:    g = 8'hDD;
         5'd2:    g = 8'hA4;
         5'd3:    g = 8'h94;
         5'd4:    g = 8'hD1;
         5'd5:    g = 8'h92;
         5'd6:    g = 8'h82;
         5'd7:    g = 8'hDC;
         5'd8:    g = 8'h80;
         5'd9:    g = 8'h90;
         5'd10:   g = 8'hC0;
         5'd11:   g = 8'h83;
         5'd12:   g = 8'hAA;
         5'd13:   g = 8'h85;
         5'd14:   g = 8'hA2;
         5'd15:   g = 8'hE2;
         5'd16:   g = 8'hC1;
         5'd17:   g = 8'hAB;
         5'd18:   g = 8'hC8;
         5'd19:   g = 8'h89;
         5'd20:   g = 8'hE0;
         5'd21:   g = 8'h87;
         5'd22:   g = 8'hF7;
         5'd23:   g = 8'hFF;
         default: g = 8'hFF;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/vfd_scan_frame_controller.sv =====
// scan item: busy in the read state, which registers the result strobe
// in-range bit and digit items: busy in the read state (frame store read, then row write)
// fill item: busy while every row is written, one row written per cycle
// led and ignored items: no busy cycle; no new item, scan or other, is taken while busy
// synchronous reset: frame reads all ones, leds zero, gate zero
// results are strobed for one cycle; the receiver cannot stall
module vfd_scan_frame_controller import vfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  vfd_req_type req_item,
   output logic        busy,
   output logic        rsp_strobe,
   output vfd_rsp_type rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_FILL = 3'b100
   } vfd_state_type;

   vfd_state_type       state_ff, state_in;
   vfd_req_type         item_ff, item_in;
   logic [ROW_W-1:0]    addr_ff, addr_in;
   logic [GATE_W-1:0]   gate_ff, gate_in;
   logic [NUM_LEDS-1:0] led_ff, led_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   vfd_rsp_type         rsp_ff, rsp_in;

   logic                rd_en;
   logic [ROW_W-1:0]    rd_addr;
   logic [SEG_W-1:0]    rd_data;
   vfd_wr_type          wr;
   vfd_alu_type         alu_res;
   logic [4:0]          digit_row;

   vfd_frame_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   vfd_row_alu u_alu (
      .item     (item_ff),
      .row_data (rd_data),
      .gate     (gate_ff),
      .leds     (led_ff),
      .res      (alu_res)
   );

   assign digit_row = 5'(req_item.digit_pos) + 5'd2;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      addr_in       = addr_ff;
      gate_in       = gate_ff;
      led_in        = led_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = gate_ff[ROW_W-1:0];
      wr            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in = req_item;
               case (req_item.req_type)
                  REQ_SCAN: begin
                     rd_en    = 1'b1;
                     state_in = ST_READ;
                  end
                  REQ_BIT: begin
                     if (5'(req_item.gate_row) < 5'(NUM_GATES)) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_item.gate_row[ROW_W-1:0];
                        state_in = ST_READ;
                     end
                  end
                  REQ_DIGIT: begin
                     if (digit_row < 5'(NUM_GATES) &&
                         req_item.digit_code < 5'(GLYPH_COUNT)) begin
                        rd_en    = 1'b1;
                        rd_addr  = digit_row[ROW_W-1:0];
                        state_in = ST_READ;
                     end
                  end
                  REQ_LED: begin
                     for (int i = 0; i < NUM_LEDS; i++) begin
                        if (4'(req_item.led_index) == 4'(i)) begin
                           led_in[i] = req_item.bit_value;
                        end
                     end
                  end
                  REQ_FILL: begin
                     led_in   = {NUM_LEDS{req_item.bit_value}};
                     rd_addr  = '0;
                     state_in = ST_FILL;
                  end
                  default: ;
               endcase
               addr_in = rd_addr;
            end
         end
         ST_READ: begin
            if (item_ff.req_type == REQ_SCAN) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.shift_word   = alu_res.word;
               rsp_in.scan_gate    = gate_ff;
               gate_in = (gate_ff == GATE_W'(NUM_GATES - 1)) ? '0 : gate_ff + 1'b1;
            end else begin
               wr.en   = 1'b1;
               wr.addr = addr_ff;
               wr.data = alu_res.new_row;
            end
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            wr.en   = 1'b1;
            wr.addr = addr_ff;
            wr.data = alu_res.new_row;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == ROW_W'(NUM_GATES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gate_ff       <= '0;
         led_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gate_ff       <= gate_in;
         led_ff        <= led_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/vfd_frame_ram.sv =====
module vfd_frame_ram import vfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_addr,
   input  vfd_wr_type       wr,
   output logic [SEG_W-1:0] rd_data
);

   logic [SEG_W-1:0]     frame_mem [NUM_GATES];
   logic [NUM_GATES-1:0] valid_ff;
   logic [NUM_GATES-1:0] valid_in;
   logic [SEG_W-1:0]     rd_data_ff;
   logic                 rd_valid_ff;

   // rows never written read as all ones (segments off)
   assign valid_in = valid_ff | (wr.en ? (NUM_GATES'(1) << wr.addr) : '0);
   assign rd_data  = rd_valid_ff ? rd_data_ff : '1;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= frame_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/vfd_row_alu.sv =====
module vfd_row_alu import vfd_pkg::*; (
   input  vfd_req_type         item,
   input  logic [SEG_W-1:0]    row_data,
   input  logic [GATE_W-1:0]   gate,
   input  logic [NUM_LEDS-1:0] leds,
   output vfd_alu_type         res
);

   always_comb begin
      logic [63:0]      w;
      logic [7:0]       g;
      logic [SEG_W-1:0] nr;
      nr = row_data;
      g  = vfd_glyph(item.digit_code);
      case (item.req_type)
         REQ_BIT:   nr[item.seg_column] = item.bit_value;
         REQ_DIGIT: nr[7:1] = g[6:0];
         REQ_FILL:  nr = {SEG_W{~item.bit_value}};
         default:   nr = row_data;
      endcase
      // scan word: row, active-low gate select, then leds
      w = 64'(row_data);
      for (int i = 0; i < NUM_GATES; i++) begin
         w[SEG_W + i] = (GATE_W'(i) != gate);
      end
      w = w | (64'(leds) << (SEG_W + NUM_GATES));
      res.new_row = nr;
      res.word    = w[WORD_W-1:0];
   end

endmodule

// ===== rtl/vfd_checker.sv =====
`include "vfd_scan_frame_controller_defines.svh"

module vfd_checker import vfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input vfd_req_type req_item,
   input logic        busy,
   input logic        rsp_strobe,
   input vfd_rsp_type rsp_item
);

   logic scan_accept;

   assign scan_accept = start && !busy && (req_item.req_type == REQ_SCAN);

   `VFD_ASSERT_NEXT(a_scan_busy, scan_accept, busy, "scan item did not raise busy")
   `VFD_ASSERT_NOW(a_scan_rsp, scan_accept, ##2 rsp_strobe, "scan item gave no result")
   `VFD_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result strobe held twice")
   `VFD_ASSERT_NOW(a_gate_range, rsp_strobe, rsp_item.scan_gate < GATE_W'(NUM_GATES), "bad gate")
   `VFD_ASSERT_NOW(a_gate_sel, rsp_strobe, $countones(rsp_item.shift_word[SEG_W +: NUM_GATES]) == NUM_GATES - 1, "gate select not one-cold")

endmodule

bind vfd_scan_frame_controller vfd_checker u_vfd_checker (.*);
